@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the glyph rectangle unit.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SGR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds during reset.
`define SGR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ rtl/sgr_pkg.sv @@
// Shared types, constants and functions of the scaled glyph rectangle unit.
// Depends on nothing; imported by the front, back and top modules.
package sgr_pkg;

  // Configuration port shape and register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int SCALE_REG_W = 4;
  localparam int FRAME_REG_W = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_SCALE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [SCALE_REG_W-1:0] SCALE_RESET  = 4'd2;
  localparam logic [FRAME_REG_W-1:0] WIDTH_RESET  = 11'd480;
  localparam logic [FRAME_REG_W-1:0] HEIGHT_RESET = 11'd272;

  // Field widths and glyph geometry.
  localparam int COORD_W      = 10;
  localparam int POS_W        = 8;
  localparam int CODE_W       = 8;
  localparam int COLOR_W      = 16;
  localparam int SIZE_W       = 4;
  localparam int GLYPH_ROWS   = 5;
  localparam int GLYPH_COLS   = 3;
  localparam int DOTS         = GLYPH_ROWS * GLYPH_COLS;
  localparam int DOT_IDX_W    = 4;
  localparam int CELL_SHIFT   = 2;   // character advance of four dots
  localparam int COORD_MAX    = 1023;
  localparam int POS_MAX      = 255;

  typedef logic [DOTS-1:0] dot_mask_t;

  // One result item as it sits in the output queue.
  typedef struct packed {
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [SIZE_W-1:0]  rect_w;
    logic [SIZE_W-1:0]  rect_h;
    logic [COLOR_W-1:0] fill_color;
    logic               last_rect;
  } rect_t;

  // Width of a saturated scale.
  function automatic int scale_w(int max_scale);
    return $clog2(max_scale + 1);
  endfunction

  // Width of a saturated frame size.
  function automatic int frame_w(int frame_max);
    return $clog2(frame_max + 1);
  endfunction

  // Width that holds every coordinate, coordinate plus scale and frame size.
  function automatic int coord_w(int max_scale, int frame_max);
    int xw;
    int yw;
    int fw;
    int m;
    xw = $clog2(COORD_MAX + POS_MAX * 4 * max_scale + 3 * max_scale + 1);
    yw = $clog2(COORD_MAX + GLYPH_ROWS * max_scale + 1);
    fw = $clog2(frame_max + 1);
    m = xw;
    if (yw > m) m = yw;
    if (fw > m) m = fw;
    return m;
  endfunction

  // Dot mask from five rows; bit 2 of a row is the left column,
  // mask bit row*3+col.
  function automatic dot_mask_t rows2mask(logic [2:0] r0, logic [2:0] r1,
                                          logic [2:0] r2, logic [2:0] r3,
                                          logic [2:0] r4);
    dot_mask_t m;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      m[c]      = r0[2-c];
      m[3 + c]  = r1[2-c];
      m[6 + c]  = r2[2-c];
      m[9 + c]  = r3[2-c];
      m[12 + c] = r4[2-c];
    end
    return m;
  endfunction

  // Font ROM: 34 glyphs, anything else is blank.
  function automatic dot_mask_t glyph_mask(logic [CODE_W-1:0] code);
    dot_mask_t m;
    unique case (code)
      "0":     m = rows2mask(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
      "1":     m = rows2mask(3'd2, 3'd6, 3'd2, 3'd2, 3'd7);
      "2":     m = rows2mask(3'd7, 3'd1, 3'd7, 3'd4, 3'd7);
      "3":     m = rows2mask(3'd7, 3'd1, 3'd7, 3'd1, 3'd7);
      "4":     m = rows2mask(3'd5, 3'd5, 3'd7, 3'd1, 3'd1);
      "5":     m = rows2mask(3'd7, 3'd4, 3'd7, 3'd1, 3'd7);
      "6":     m = rows2mask(3'd7, 3'd4, 3'd7, 3'd5, 3'd7);
      "7":     m = rows2mask(3'd7, 3'd1, 3'd1, 3'd1, 3'd1);
      "8":     m = rows2mask(3'd7, 3'd5, 3'd7, 3'd5, 3'd7);
      "9":     m = rows2mask(3'd7, 3'd5, 3'd7, 3'd1, 3'd7);
      "A":     m = rows2mask(3'd2, 3'd5, 3'd7, 3'd5, 3'd5);
      "B":     m = rows2mask(3'd6, 3'd5, 3'd6, 3'd5, 3'd6);
      "C":     m = rows2mask(3'd3, 3'd4, 3'd4, 3'd4, 3'd3);
      "D":     m = rows2mask(3'd6, 3'd5, 3'd5, 3'd5, 3'd6);
      "E":     m = rows2mask(3'd7, 3'd4, 3'd6, 3'd4, 3'd7);
      "F":     m = rows2mask(3'd7, 3'd4, 3'd6, 3'd4, 3'd4);
      "G":     m = rows2mask(3'd3, 3'd4, 3'd5, 3'd5, 3'd3);
      "H":     m = rows2mask(3'd5, 3'd5, 3'd7, 3'd5, 3'd5);
      "I":     m = rows2mask(3'd7, 3'd2, 3'd2, 3'd2, 3'd7);
      "L":     m = rows2mask(3'd4, 3'd4, 3'd4, 3'd4, 3'd7);
      "M":     m = rows2mask(3'd5, 3'd7, 3'd7, 3'd5, 3'd5);
      "N":     m = rows2mask(3'd5, 3'd7, 3'd7, 3'd7, 3'd5);
      "O":     m = rows2mask(3'd2, 3'd5, 3'd5, 3'd5, 3'd2);
      "P":     m = rows2mask(3'd6, 3'd5, 3'd6, 3'd4, 3'd4);
      "R":     m = rows2mask(3'd6, 3'd5, 3'd6, 3'd5, 3'd5);
      "S":     m = rows2mask(3'd3, 3'd4, 3'd2, 3'd1, 3'd6);
      "T":     m = rows2mask(3'd7, 3'd2, 3'd2, 3'd2, 3'd2);
      "U":     m = rows2mask(3'd5, 3'd5, 3'd5, 3'd5, 3'd7);
      "V":     m = rows2mask(3'd5, 3'd5, 3'd5, 3'd5, 3'd2);
      "X":     m = rows2mask(3'd5, 3'd5, 3'd2, 3'd5, 3'd5);
      "Y":     m = rows2mask(3'd5, 3'd5, 3'd2, 3'd2, 3'd2);
      "/":     m = rows2mask(3'd1, 3'd1, 3'd2, 3'd4, 3'd4);
      ":":     m = rows2mask(3'd0, 3'd2, 3'd0, 3'd2, 3'd0);
      "-":     m = rows2mask(3'd0, 3'd0, 3'd7, 3'd0, 3'd0);
      default: m = '0;
    endcase
    return m;
  endfunction

  // Row of a dot index.
  function automatic logic [2:0] dot_row(logic [DOT_IDX_W-1:0] idx);
    logic [2:0] r;
    priority if (idx < 4'd3)  r = 3'd0;
    else if (idx < 4'd6)      r = 3'd1;
    else if (idx < 4'd9)      r = 3'd2;
    else if (idx < 4'd12)     r = 3'd3;
    else                      r = 3'd4;
    return r;
  endfunction

  // Column of a dot index.
  function automatic logic [1:0] dot_col(logic [DOT_IDX_W-1:0] idx);
    logic [DOT_IDX_W-1:0] base;
    base = DOT_IDX_W'(dot_row(idx)) * DOT_IDX_W'(GLYPH_COLS);
    return 2'(idx - base);
  endfunction

endpackage

@@ rtl/sgr_fifo.sv @@
// Small register queue used between the front and back and at the output.
// Depends on nothing but its parameters.
module sgr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

@@ rtl/sgr_front.sv @@
// Front part: takes character items, looks up the glyph, places it and marks
// the dots that land inside the frame. Depends on sgr_pkg.
module sgr_front #(
  parameter int MAX_SCALE = 8,
  parameter int FRAME_MAX = 1024
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        push,
  output logic                                        full,
  input  logic [sgr_pkg::COORD_W-1:0]                 base_x,
  input  logic [sgr_pkg::COORD_W-1:0]                 base_y,
  input  logic [sgr_pkg::POS_W-1:0]                   char_pos,
  input  logic [sgr_pkg::CODE_W-1:0]                  char_code,
  input  logic [sgr_pkg::COLOR_W-1:0]                 ink_color,
  input  logic [sgr_pkg::scale_w(MAX_SCALE)-1:0]      scale,
  input  logic [sgr_pkg::frame_w(FRAME_MAX)-1:0]      fw,
  input  logic [sgr_pkg::frame_w(FRAME_MAX)-1:0]      fh,
  output logic                                        q_push,
  input  logic                                        q_full,
  output logic [sgr_pkg::coord_w(MAX_SCALE, FRAME_MAX)-1:0] q_left,
  output logic [sgr_pkg::COORD_W-1:0]                 q_top,
  output sgr_pkg::dot_mask_t                          q_mask,
  output logic [sgr_pkg::COLOR_W-1:0]                 q_color
);
  import sgr_pkg::*;

  localparam int S_W = scale_w(MAX_SCALE);
  localparam int C_W = coord_w(MAX_SCALE, FRAME_MAX);

  logic                    v1;
  logic [C_W-1:0]          left1;
  logic [COORD_W-1:0]      top1;
  dot_mask_t               mask1;
  logic [COLOR_W-1:0]      color1;
  logic [POS_W+S_W-1:0]    pos_prod;
  logic                    accept;
  logic                    advance;
  logic [GLYPH_COLS-1:0]   col_vis;
  logic [GLYPH_ROWS-1:0]   row_vis;
  dot_mask_t               emask;

  // char_pos * scale; times four it is the character offset in the run.
  assign pos_prod = (POS_W + S_W)'(char_pos) * (POS_W + S_W)'(scale);

  assign accept  = push && !full;
  assign advance = !v1 || !q_full || (emask == '0);
  assign full    = v1 && !advance;

  // Lookup stage; zero scale turns every glyph blank.
  always_ff @(posedge clk) begin
    if (accept) begin
      left1  <= C_W'(base_x) + (C_W'(pos_prod) << CELL_SHIFT);
      top1   <= base_y;
      mask1  <= (scale == '0) ? '0 : glyph_mask(char_code);
      color1 <= ink_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (advance) begin
      v1 <= 1'b0;
    end
  end

  // Column and row visibility against the right and bottom frame edges.
  always_comb begin
    for (int c = 0; c < GLYPH_COLS; c++) begin
      col_vis[c] = (left1 + C_W'(scale) * C_W'(c)) < C_W'(fw);
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      row_vis[r] = (C_W'(top1) + C_W'(scale) * C_W'(r)) < C_W'(fh);
    end
    for (int d = 0; d < DOTS; d++) begin
      emask[d] = mask1[d] && col_vis[d % GLYPH_COLS] && row_vis[d / GLYPH_COLS];
    end
  end

  // Characters with no visible dot never reach the queue.
  assign q_push  = v1 && (emask != '0) && !q_full;
  assign q_left  = left1;
  assign q_top   = top1;
  assign q_mask  = emask;
  assign q_color = color1;
endmodule

@@ rtl/sgr_back.sv @@
// Back part: walks a character's visible dots, one square a cycle unless
// stalled; clips each square and flags the last. Depends on sgr_pkg.
module sgr_back #(
  parameter int MAX_SCALE = 8,
  parameter int FRAME_MAX = 1024
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        q_empty,
  output logic                                        q_pop,
  input  logic [sgr_pkg::coord_w(MAX_SCALE, FRAME_MAX)-1:0] q_left,
  input  logic [sgr_pkg::COORD_W-1:0]                 q_top,
  input  sgr_pkg::dot_mask_t                          q_mask,
  input  logic [sgr_pkg::COLOR_W-1:0]                 q_color,
  input  logic [sgr_pkg::scale_w(MAX_SCALE)-1:0]      scale,
  input  logic [sgr_pkg::frame_w(FRAME_MAX)-1:0]      fw,
  input  logic [sgr_pkg::frame_w(FRAME_MAX)-1:0]      fh,
  input  logic                                        out_full,
  output logic                                        out_push,
  output sgr_pkg::rect_t                              out_rect
);
  import sgr_pkg::*;

  localparam int C_W = coord_w(MAX_SCALE, FRAME_MAX);

  logic                  busy;
  logic [C_W-1:0]        left;
  logic [COORD_W-1:0]    top;
  dot_mask_t             rem;
  logic [COLOR_W-1:0]    color;
  dot_mask_t             onehot;
  logic [DOT_IDX_W-1:0]  idx;
  logic                  step;
  logic                  last;
  logic                  load;
  logic [C_W-1:0]        x;
  logic [C_W-1:0]        y;
  logic [C_W-1:0]        sw;

  // Lowest remaining dot.
  always_comb begin
    onehot = rem & (~rem + 1'b1);
    idx    = '0;
    for (int i = 0; i < DOTS; i++) begin
      if (onehot[i]) begin
        idx = idx | DOT_IDX_W'(i);
      end
    end
  end

  assign step  = busy && !out_full;
  assign last  = ((rem & ~onehot) == '0);
  assign load  = !q_empty && (!busy || (step && last));
  assign q_pop = load;

  // Entry register.
  always_ff @(posedge clk) begin
    if (load) begin
      left  <= q_left;
      top   <= q_top;
      rem   <= q_mask;
      color <= q_color;
    end else if (step) begin
      rem <= rem & ~onehot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (step && last) begin
      busy <= 1'b0;
    end
  end

  // Square position and clipping at the right and bottom edges.
  always_comb begin
    sw = C_W'(scale);
    x  = left + sw * C_W'(dot_col(idx));
    y  = C_W'(top) + sw * C_W'(dot_row(idx));
    out_rect.rect_x     = x[COORD_W-1:0];
    out_rect.rect_y     = y[COORD_W-1:0];
    out_rect.rect_w     = ((x + sw) > C_W'(fw)) ? SIZE_W'(C_W'(fw) - x) : SIZE_W'(sw);
    out_rect.rect_h     = ((y + sw) > C_W'(fh)) ? SIZE_W'(C_W'(fh) - y) : SIZE_W'(sw);
    out_rect.fill_color = color;
    out_rect.last_rect  = last;
  end

  assign out_push = step;
endmodule

@@ rtl/scaled_glyph_rect_generator_unit.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// input    | push / full          | base_x, base_y, char_pos, char_code, ink_color
// result   | empty / pop          | rect_x, rect_y, rect_w, rect_h, fill_color, last_rect
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A character with n visible dots gives n back squares, one per cycle while the
// output queue has room; one with none uses no back time. The first square of an
// item passes the front lookup register, the inner queue, the back entry register
// and the output queue. A stalled result side fills the output and inner queues,
// then full rises. Reset clears all queues, restores scale 2 and a 480x272 frame.
// Top level of the scaled glyph rectangle unit: config registers, front,
// inner queue, back and output queue. Depends on sgr_pkg and the submodules.
module scaled_glyph_rect_generator_unit #(
  parameter int MAX_SCALE = 8,
  parameter int FRAME_MAX = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [sgr_pkg::COORD_W-1:0]        base_x,
  input  logic [sgr_pkg::COORD_W-1:0]        base_y,
  input  logic [sgr_pkg::POS_W-1:0]          char_pos,
  input  logic [sgr_pkg::CODE_W-1:0]         char_code,
  input  logic [sgr_pkg::COLOR_W-1:0]        ink_color,
  output logic                               empty,
  input  logic                               pop,
  output logic [sgr_pkg::COORD_W-1:0]        rect_x,
  output logic [sgr_pkg::COORD_W-1:0]        rect_y,
  output logic [sgr_pkg::SIZE_W-1:0]         rect_w,
  output logic [sgr_pkg::SIZE_W-1:0]         rect_h,
  output logic [sgr_pkg::COLOR_W-1:0]        fill_color,
  output logic                               last_rect,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sgr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sgr_pkg::*;

  localparam int S_W   = scale_w(MAX_SCALE);
  localparam int F_W   = frame_w(FRAME_MAX);
  localparam int C_W   = coord_w(MAX_SCALE, FRAME_MAX);
  localparam int SCW   = (S_W > SCALE_REG_W) ? S_W : SCALE_REG_W;
  localparam int FCW   = (F_W > FRAME_REG_W) ? F_W : FRAME_REG_W;
  localparam int ENT_W = C_W + COORD_W + DOTS + COLOR_W;

  logic [SCALE_REG_W-1:0] glyph_scale;
  logic [FRAME_REG_W-1:0] frame_width;
  logic [FRAME_REG_W-1:0] frame_height;
  logic [S_W-1:0]         scale;
  logic [F_W-1:0]         fw;
  logic [F_W-1:0]         fh;

  logic                   f_push;
  logic                   f_full;
  logic [C_W-1:0]         f_left;
  logic [COORD_W-1:0]     f_top;
  dot_mask_t              f_mask;
  logic [COLOR_W-1:0]     f_color;
  logic [ENT_W-1:0]       q_rd;
  logic                   q_empty;
  logic                   q_pop;
  logic                   o_push;
  logic                   o_full;
  rect_t                  o_rect;
  rect_t                  o_head;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_scale  <= SCALE_RESET;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_GLYPH_SCALE) begin
        glyph_scale <= cfg_data[SCALE_REG_W-1:0];
      end
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[FRAME_REG_W-1:0];
      end
      if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data[FRAME_REG_W-1:0];
      end
    end
  end

  // Saturated scale and frame size.
  assign scale = S_W'((SCW'(glyph_scale) > SCW'(MAX_SCALE)) ? SCW'(MAX_SCALE)
                                                             : SCW'(glyph_scale));
  assign fw = F_W'((FCW'(frame_width) > FCW'(FRAME_MAX)) ? FCW'(FRAME_MAX)
                                                          : FCW'(frame_width));
  assign fh = F_W'((FCW'(frame_height) > FCW'(FRAME_MAX)) ? FCW'(FRAME_MAX)
                                                           : FCW'(frame_height));

  // Front part.
  sgr_front #(.MAX_SCALE(MAX_SCALE), .FRAME_MAX(FRAME_MAX)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .base_x    (base_x),
    .base_y    (base_y),
    .char_pos  (char_pos),
    .char_code (char_code),
    .ink_color (ink_color),
    .scale     (scale),
    .fw        (fw),
    .fh        (fh),
    .q_push    (f_push),
    .q_full    (f_full),
    .q_left    (f_left),
    .q_top     (f_top),
    .q_mask    (f_mask),
    .q_color   (f_color)
  );

  // Queue of placed characters between front and back.
  sgr_fifo #(.WIDTH(ENT_W), .DEPTH(2)) u_char_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data ({f_left, f_top, f_mask, f_color}),
    .full    (f_full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  // Back part.
  sgr_back #(.MAX_SCALE(MAX_SCALE), .FRAME_MAX(FRAME_MAX)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_left   (q_rd[ENT_W-1 -: C_W]),
    .q_top    (q_rd[COLOR_W+DOTS +: COORD_W]),
    .q_mask   (q_rd[COLOR_W +: DOTS]),
    .q_color  (q_rd[COLOR_W-1:0]),
    .scale    (scale),
    .fw       (fw),
    .fh       (fh),
    .out_full (o_full),
    .out_push (o_push),
    .out_rect (o_rect)
  );

  // Output queue of finished squares.
  sgr_fifo #(.WIDTH($bits(rect_t)), .DEPTH(2)) u_rect_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (o_push),
    .wr_data (o_rect),
    .full    (o_full),
    .rd_en   (pop),
    .rd_data (o_head),
    .empty   (empty)
  );

  assign rect_x     = o_head.rect_x;
  assign rect_y     = o_head.rect_y;
  assign rect_w     = o_head.rect_w;
  assign rect_h     = o_head.rect_h;
  assign fill_color = o_head.fill_color;
  assign last_rect  = o_head.last_rect;
endmodule

@@ rtl/sgr_checker.sv @@
// Port-level checker for the scaled glyph rectangle unit, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sgr_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [9:0]  rect_x,
  input logic [9:0]  rect_y,
  input logic [3:0]  rect_w,
  input logic [3:0]  rect_h,
  input logic [15:0] fill_color,
  input logic        last_rect
);
  // Reset leaves no result waiting and the input open.
  `SGR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty)
  `SGR_ASSERT_ALWAYS(a_reset_open, clk, rst |=> !full)

  // A waiting result holds until it is taken.
  `SGR_ASSERT(a_result_hold, clk, rst, !empty && !pop |=> !empty && $stable(rect_x) && $stable(rect_y) && $stable(rect_w) && $stable(rect_h) && $stable(fill_color) && $stable(last_rect))

  // Squares of one character follow each other without a gap.
  `SGR_ASSERT(a_run_no_gap, clk, rst, !empty && pop && !last_rect |=> !empty)
endmodule

bind scaled_glyph_rect_generator_unit sgr_checker u_sgr_checker (.*);
